// ----- rtl/page_frame_allocator_top_assert.svh -----
// assertion macros used by the checker file
// clk and rst_n are expected in the scope of use
`ifndef PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// property that holds at every edge
`define PFA_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pfa check failed");

// same-cycle implication
`define PFA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfa check failed");

// next-cycle implication
`define PFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfa check failed");

`endif

// ----- rtl/pfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// types, codes and constants of the page frame allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

    localparam int PAGE_W   = 12;
    localparam int ENTRY_W  = PAGE_W + 1;
    localparam int CFG_W    = 13;
    localparam int WORD_BITS = 32;
    localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

    localparam logic [CFG_W-1:0] TOTAL_PAGES_RST = 13'd4096;
    localparam logic [CFG_W-1:0] BOOT_PAGES_RST  = 13'd256;

    // request codes
    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_INIT  = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_OOM   = 2'd1;
    localparam logic [1:0] STATUS_FREE0 = 2'd2;

    // source codes
    localparam logic [1:0] SRC_STACK   = 2'd0;
    localparam logic [1:0] SRC_RECLAIM = 2'd1;
    localparam logic [1:0] SRC_BITMAP  = 2'd2;
    localparam logic [1:0] SRC_NONE    = 2'd3;

    // register indexes
    localparam logic REG_TOTAL_PAGES = 1'b0;
    localparam logic REG_BOOT_PAGES  = 1'b1;

    typedef struct packed {
        logic [1:0]        func;
        logic [PAGE_W-1:0] page_frame;
    } pfa_req_t;

    typedef struct packed {
        logic [PAGE_W-1:0] alloc_frame;
        logic [1:0]        status;
        logic [1:0]        source;
    } pfa_rsp_t;

    typedef struct packed {
        logic             index;
        logic [CFG_W-1:0] data;
    } pfa_cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT_START,
        OP_INIT_WORD,
        OP_CAPTURE,
        OP_POP,
        OP_BM_RD_STACK,
        OP_BM_RD_PAGE,
        OP_BM_CLR,
        OP_BM_SET,
        OP_PUSH,
        OP_SCAN_START,
        OP_SCAN_RD,
        OP_SCAN_TAKE,
        OP_SCAN_NEXT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       emit;
        logic [1:0] status;
        logic [1:0] source;
        logic       use_page;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       depth_zero;
        logic       depth_full;
        logic       fill_zero;
        logic       fill_full;
        logic       page_zero;
        logic       page_oor;
        logic       sweep_last;
        logic       scan_end;
        logic       scan_hit;
        logic       out_busy;
    } dp_stat_t;

endpackage

// ----- rtl/pfa_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_chan_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface pfa_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/pfa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_datapath
// bitmap and stack memories, counters and result register of the allocator
// ----------------------------------------------------------------------------
module pfa_datapath
    import pfa_pkg::*;
#(
    parameter int MAX_PAGES      = 4096,
    parameter int FRAME_CAPACITY = 1022
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  pfa_req_t            req_payload,
    input  logic                cfg_write,
    input  pfa_cfg_t            cfg_payload,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output pfa_rsp_t            rsp_payload
);

    localparam int NW  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int CW  = $clog2(NW + 1);
    localparam int PW  = $clog2(MAX_PAGES);
    localparam int SAW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int DW  = $clog2(MAX_PAGES + 1);
    localparam int FW  = $clog2(FRAME_CAPACITY + 1);

    logic [WORD_BITS-1:0] bm_mem [NW];
    logic [ENTRY_W-1:0]   st_mem [MAX_PAGES];

    logic [CFG_W-1:0]     total_reg, total_next;
    logic [CFG_W-1:0]     boot_reg, boot_next;
    logic [CW-1:0]        addr_reg, addr_next;
    logic [DW-1:0]        depth_reg, depth_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic                 valid_reg, valid_next;

    logic [1:0]           func_reg;
    logic [PAGE_W-1:0]    in_page_reg;
    logic [PW-1:0]        page_reg;
    logic [WORD_BITS-1:0] bm_rd_reg;
    logic [ENTRY_W-1:0]   st_rd_reg;
    pfa_rsp_t             out_reg;

    logic [FW-1:0]        fill_eff;
    logic                 fill_full;
    logic [DW-1:0]        depth_m1;
    logic [PW-1:0]        stack_page;
    logic [WW-1:0]        page_word;
    logic [WW-1:0]        stack_word;
    logic [4:0]           page_bit;

    logic [31:0]          tot32, lo32, base32;
    logic [WORD_BITS-1:0] ge_mask, lt_mask, init_word;
    logic [16:0]          lim17;
    logic [16:0]          limit17;

    logic [WORD_BITS-1:0] scan_word, low_bit;
    logic [4:0]           hit_idx;

    logic                 bm_we;
    logic [WW-1:0]        bm_waddr;
    logic [WORD_BITS-1:0] bm_wdata;
    logic                 bm_re;
    logic [WW-1:0]        bm_raddr;

    // frame fill counts from zero whenever the stack is empty
    assign fill_eff   = (depth_reg == '0) ? '0 : fill_reg;
    assign fill_full  = fill_eff >= FW'(FRAME_CAPACITY);
    assign depth_m1   = depth_reg - DW'(1);
    assign stack_page = PW'(st_rd_reg[PAGE_W-1:0]);
    assign page_word  = WW'(page_reg >> 5);
    assign stack_word = WW'(stack_page >> 5);
    assign page_bit   = page_reg[4:0];

    // init pattern for one bitmap word
    always_comb
    begin
        tot32  = (32'(total_reg) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES) : 32'(total_reg);
        lo32   = (boot_reg == '0) ? 32'd1 : 32'(boot_reg);
        base32 = 32'(addr_reg) << 5;
        if (lo32 <= base32)
            ge_mask = WORD_ONES;
        else if (lo32 >= base32 + 32'(WORD_BITS))
            ge_mask = '0;
        else
            ge_mask = WORD_ONES << 5'(lo32 - base32);
        if (tot32 >= base32 + 32'(WORD_BITS))
            lt_mask = WORD_ONES;
        else if (tot32 <= base32)
            lt_mask = '0;
        else
            lt_mask = ~(WORD_ONES << 5'(tot32 - base32));
        init_word = ge_mask & lt_mask;
    end

    // scan limit in words
    always_comb
    begin
        lim17   = (17'(total_reg) + 17'd31) >> 5;
        limit17 = (lim17 > 17'(NW)) ? 17'(NW) : lim17;
    end

    // lowest free page in the word under scan, page zero excluded
    always_comb
    begin
        scan_word = bm_rd_reg & ~((addr_reg == '0) ? WORD_BITS'(1) : '0);
        low_bit   = scan_word & (~scan_word + WORD_BITS'(1));
        hit_idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (scan_word[i])
                hit_idx = 5'(i);
        end
    end

    // bitmap port selection
    always_comb
    begin
        bm_we    = 1'b0;
        bm_waddr = page_word;
        bm_wdata = bm_rd_reg;
        bm_re    = 1'b0;
        bm_raddr = page_word;
        case (cmd.op)
            OP_INIT_WORD:
            begin
                bm_we    = 1'b1;
                bm_waddr = addr_reg[WW-1:0];
                bm_wdata = init_word;
            end
            OP_BM_CLR:
            begin
                bm_we    = 1'b1;
                bm_wdata = bm_rd_reg & ~(WORD_BITS'(1) << page_bit);
            end
            OP_BM_SET:
            begin
                bm_we    = 1'b1;
                bm_wdata = bm_rd_reg | (WORD_BITS'(1) << page_bit);
            end
            OP_SCAN_TAKE:
            begin
                bm_we    = 1'b1;
                bm_waddr = addr_reg[WW-1:0];
                bm_wdata = bm_rd_reg & ~low_bit;
            end
            OP_BM_RD_STACK:
            begin
                bm_re    = 1'b1;
                bm_raddr = stack_word;
            end
            OP_BM_RD_PAGE:
            begin
                bm_re = 1'b1;
            end
            OP_SCAN_RD:
            begin
                bm_re    = 1'b1;
                bm_raddr = addr_reg[WW-1:0];
            end
            default:
            begin
                bm_we = 1'b0;
            end
        endcase
    end

    // control state next values
    always_comb
    begin
        total_next = total_reg;
        boot_next  = boot_reg;
        addr_next  = addr_reg;
        depth_next = depth_reg;
        fill_next  = fill_reg;
        valid_next = valid_reg && !rsp_ready;
        if (cfg_write)
        begin
            if (cfg_payload.index == REG_TOTAL_PAGES)
                total_next = cfg_payload.data;
            else
                boot_next = cfg_payload.data;
        end
        case (cmd.op)
            OP_INIT_START:
            begin
                addr_next  = '0;
                depth_next = '0;
                fill_next  = '0;
            end
            OP_INIT_WORD, OP_SCAN_NEXT:
            begin
                addr_next = addr_reg + CW'(1);
            end
            OP_SCAN_START:
            begin
                addr_next = '0;
                fill_next = '0;
            end
            OP_POP:
            begin
                depth_next = depth_m1;
                fill_next  = (fill_reg == '0) ? FW'(FRAME_CAPACITY) : fill_reg - FW'(1);
            end
            OP_PUSH:
            begin
                depth_next = depth_reg + DW'(1);
                fill_next  = fill_full ? '0 : fill_eff + FW'(1);
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
        if (cmd.emit)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_PAGES_RST;
            boot_reg  <= BOOT_PAGES_RST;
            addr_reg  <= '0;
            depth_reg <= '0;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            boot_reg  <= boot_next;
            addr_reg  <= addr_next;
            depth_reg <= depth_next;
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
    end

    // payload registers and memories
    always_ff @(posedge clk)
    begin
        if (bm_we)
            bm_mem[bm_waddr] <= bm_wdata;
        if (bm_re)
            bm_rd_reg <= bm_mem[bm_raddr];
        if (cmd.op == OP_PUSH)
            st_mem[depth_reg[SAW-1:0]] <= {fill_full, PAGE_W'(page_reg)};
        if (cmd.op == OP_POP)
            st_rd_reg <= st_mem[depth_m1[SAW-1:0]];
        if (cmd.op == OP_CAPTURE)
        begin
            func_reg    <= req_payload.func;
            in_page_reg <= req_payload.page_frame;
            page_reg    <= PW'(req_payload.page_frame);
        end
        if (cmd.op == OP_BM_RD_STACK)
            page_reg <= stack_page;
        if (cmd.op == OP_SCAN_TAKE)
            page_reg <= PW'({addr_reg[WW-1:0], hit_idx});
        if (cmd.emit)
        begin
            out_reg.alloc_frame <= cmd.use_page ? PAGE_W'(page_reg) : '0;
            out_reg.status      <= cmd.status;
            out_reg.source      <= cmd.source;
        end
    end

    assign stat.func       = func_reg;
    assign stat.depth_zero = depth_reg == '0;
    assign stat.depth_full = depth_reg >= DW'(MAX_PAGES);
    assign stat.fill_zero  = fill_eff == '0;
    assign stat.fill_full  = fill_full;
    assign stat.page_zero  = in_page_reg == '0;
    assign stat.page_oor   = 32'(in_page_reg) >= 32'(MAX_PAGES);
    assign stat.sweep_last = addr_reg == CW'(NW - 1);
    assign stat.scan_end   = 17'(addr_reg) >= limit17;
    assign stat.scan_hit   = scan_word != '0;
    assign stat.out_busy   = valid_reg;

    assign rsp_valid   = valid_reg;
    assign rsp_payload = out_reg;

endmodule

// ----- rtl/pfa_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_controller
// sequencer issuing datapath commands for allocate, free and init
// ----------------------------------------------------------------------------
module pfa_controller
    import pfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_POP_WAIT,
        ST_CLR,
        ST_SET_RD,
        ST_SET,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   init_pend_reg, init_pend_next;
    logic   reclaim_reg, reclaim_next;

    assign req_ready = (state_reg == ST_IDLE) && !stat.out_busy;

    always_comb
    begin
        state_next     = state_reg;
        init_pend_next = init_pend_reg;
        reclaim_next   = reclaim_reg;
        cmd.op         = OP_NONE;
        cmd.emit       = 1'b0;
        cmd.status     = STATUS_OK;
        cmd.source     = SRC_NONE;
        cmd.use_page   = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.op = OP_INIT_WORD;
                if (stat.sweep_last)
                begin
                    cmd.emit       = init_pend_reg;
                    init_pend_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (stat.func)
                    FUNC_ALLOC:
                    begin
                        if (!stat.depth_zero)
                        begin
                            cmd.op       = OP_POP;
                            reclaim_next = stat.fill_zero;
                            state_next   = ST_POP_WAIT;
                        end
                        else
                        begin
                            cmd.op     = OP_SCAN_START;
                            state_next = ST_SCAN_RD;
                        end
                    end
                    FUNC_FREE:
                    begin
                        if (stat.page_zero)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.status = STATUS_FREE0;
                            state_next = ST_IDLE;
                        end
                        else if (stat.page_oor || stat.depth_full)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (stat.fill_full)
                        begin
                            // page becomes a frame marker, bitmap untouched
                            cmd.op     = OP_PUSH;
                            cmd.emit   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            cmd.op     = OP_PUSH;
                            state_next = ST_SET_RD;
                        end
                    end
                    FUNC_INIT:
                    begin
                        cmd.op         = OP_INIT_START;
                        init_pend_next = 1'b1;
                        state_next     = ST_INIT;
                    end
                    default:
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_POP_WAIT:
            begin
                cmd.op     = OP_BM_RD_STACK;
                state_next = ST_CLR;
            end
            ST_CLR:
            begin
                cmd.op       = OP_BM_CLR;
                cmd.emit     = 1'b1;
                cmd.source   = reclaim_reg ? SRC_RECLAIM : SRC_STACK;
                cmd.use_page = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SET_RD:
            begin
                cmd.op     = OP_BM_RD_PAGE;
                state_next = ST_SET;
            end
            ST_SET:
            begin
                cmd.op     = OP_BM_SET;
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN_RD:
            begin
                if (stat.scan_end)
                begin
                    cmd.emit   = 1'b1;
                    cmd.status = STATUS_OOM;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.op     = OP_SCAN_RD;
                    state_next = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                if (stat.scan_hit)
                begin
                    cmd.op     = OP_SCAN_TAKE;
                    state_next = ST_SCAN_DONE;
                end
                else
                begin
                    cmd.op     = OP_SCAN_NEXT;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_DONE:
            begin
                cmd.emit     = 1'b1;
                cmd.source   = SRC_BITMAP;
                cmd.use_page = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_pend_reg <= 1'b0;
            reclaim_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_pend_reg <= init_pend_next;
            reclaim_reg   <= reclaim_next;
        end
    end

endmodule

// ----- rtl/page_frame_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_top
// physical page frame allocator with framed free stack and free bitmap
// ----------------------------------------------------------------------------
// req carries func and page_frame, rsp returns alloc_frame, status, source;
// cfg writes total_pages (index 0) and boot_pages (index 1), always ready
// one request is handled at a time, each gives exactly one rsp transfer
// free: frame zero, a dropped free or a new frame marker is answered at
// dispatch; otherwise the page is pushed, then its bitmap word read and set
// allocate from the stack: pop, read the popped page's bitmap word, clear it
// allocate by bitmap scan: each 32-bit word walked is read, then checked, up to
//   ceil(total_pages / 32) words, through one bitmap port
// init: the sweep writes each bitmap word (MAX_PAGES / 32), rsp with the last
// after reset the bitmap is rebuilt by the same sweep over MAX_PAGES / 32
//   words, with req held not ready
// the result sits in an output register; req stays not ready until the
//   pending rsp transfer completes, so a stalled receiver holds everything
// ----------------------------------------------------------------------------
module page_frame_allocator_top
    import pfa_pkg::*;
#(
    parameter int MAX_PAGES      = 4096,
    parameter int FRAME_CAPACITY = 1022
) (
    input  logic        clk,
    input  logic        rst_n,
    pfa_chan_if.sink    req,
    pfa_chan_if.sink    cfg,
    pfa_chan_if.source  rsp
);

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration writes land in the datapath registers directly
    assign cfg.ready = 1'b1;

    pfa_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pfa_datapath #(
        .MAX_PAGES      (MAX_PAGES),
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_payload (req.payload),
        .cfg_write   (cfg.valid),
        .cfg_payload (cfg.payload),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp_payload (rsp.payload)
    );

endmodule

// ----- rtl/pfa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_checker
// port level checks of the page frame allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "page_frame_allocator_top_assert.svh"

module pfa_checker
    import pfa_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input pfa_rsp_t rsp_payload
);

    // one request in flight at a time
    `PFA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
    // no new request while a result waits
    `PFA_ASSERT_ALWAYS(a_no_accept_while_pending, !(rsp_valid && req_ready))
    // faults never name a source
    `PFA_ASSERT_IMPL(a_fault_no_source, rsp_valid && rsp_payload.status != STATUS_OK,
        rsp_payload.source == SRC_NONE)
    // no frame handed out without a source
    `PFA_ASSERT_IMPL(a_none_zero_frame, rsp_valid && rsp_payload.source == SRC_NONE,
        rsp_payload.alloc_frame == '0)
    // stalled result holds
    `PFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_payload))

endmodule

bind page_frame_allocator_top pfa_checker u_pfa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_payload (rsp.payload)
);

// ----- dv/page_frame_allocator_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_allocator_top_tb
// self-checking bench for the page frame allocator: a directed table, then
// per-setting random traffic and a long free burst into a new frame marker;
// every rsp transfer is compared field by field with its table row or with
// a behavioral copy of the allocator
// ----------------------------------------------------------------------------
module page_frame_allocator_top_tb;
    import pfa_pkg::*;

    localparam int NPAGES   = 4096;
    localparam int FRAME_CAP = 1022;

    logic clk;
    logic rst_n;

    pfa_chan_if #(.T(pfa_req_t)) req_if ();
    pfa_chan_if #(.T(pfa_cfg_t)) cfg_if ();
    pfa_chan_if #(.T(pfa_rsp_t)) rsp_if ();

    page_frame_allocator_top #(
        .MAX_PAGES      (NPAGES),
        .FRAME_CAPACITY (FRAME_CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .cfg   (cfg_if.sink),
        .rsp   (rsp_if.source)
    );

    // clock, 12 ns period
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // behavioral copy of the allocator state
    logic              free_map [NPAGES];
    logic [ENTRY_W-1:0] lifo    [NPAGES];
    int                lifo_depth;
    int                cur_fill;
    logic [CFG_W-1:0]  reg_total;
    logic [CFG_W-1:0]  reg_boot;

    // expected responses, oldest first
    pfa_rsp_t rsp_expected [$];

    int errors;
    int n_items;
    int n_src [4];
    int n_oom;
    int n_free0;
    int n_frees;
    bit no_idle;

    // rebuild the free map from the registers and empty the stack
    function automatic void rebuild_map();
        int tot;
        int lo;
        tot = (reg_total > NPAGES) ? NPAGES : int'(reg_total);
        lo  = (reg_boot < 1) ? 1 : int'(reg_boot);
        for (int i = 0; i < NPAGES; i++)
            free_map[i] = (i >= lo && i < tot);
        lifo_depth = 0;
        cur_fill   = 0;
    endfunction

    // next response of the allocator for one request, state updated
    function automatic pfa_rsp_t alloc_predict(logic [1:0] f, logic [PAGE_W-1:0] pg);
        pfa_rsp_t r;
        logic [PAGE_W-1:0] p;
        int lim;
        bit hit;
        r.alloc_frame = '0;
        r.status      = STATUS_OK;
        r.source      = SRC_NONE;
        case (f)
            FUNC_ALLOC:
            begin
                if (lifo_depth == 0)
                    cur_fill = 0;
                if (cur_fill > 0)
                begin
                    lifo_depth--;
                    cur_fill--;
                    p = lifo[lifo_depth][PAGE_W-1:0];
                    free_map[p] = 1'b0;
                    r.alloc_frame = p;
                    r.source      = SRC_STACK;
                end
                else if (lifo_depth > 0)
                begin
                    // marker page of an emptied frame comes back
                    lifo_depth--;
                    p = lifo[lifo_depth][PAGE_W-1:0];
                    cur_fill = FRAME_CAP;
                    free_map[p] = 1'b0;
                    r.alloc_frame = p;
                    r.source      = SRC_RECLAIM;
                end
                else
                begin
                    lim = ((int'(reg_total) + 31) / 32) * 32;
                    if (lim > NPAGES)
                        lim = NPAGES;
                    hit = 1'b0;
                    for (int i = 1; i < lim && !hit; i++)
                        if (free_map[i])
                        begin
                            free_map[i]   = 1'b0;
                            r.alloc_frame = PAGE_W'(i);
                            r.source      = SRC_BITMAP;
                            hit = 1'b1;
                        end
                    if (!hit)
                        r.status = STATUS_OOM;
                end
            end
            FUNC_FREE:
            begin
                if (pg == 0)
                    r.status = STATUS_FREE0;
                else if (lifo_depth < NPAGES)
                begin
                    if (lifo_depth == 0)
                        cur_fill = 0;
                    if (cur_fill >= FRAME_CAP)
                    begin
                        // frame full: page becomes the next frame marker
                        lifo[lifo_depth] = {1'b1, pg};
                        lifo_depth++;
                        cur_fill = 0;
                    end
                    else
                    begin
                        lifo[lifo_depth] = {1'b0, pg};
                        lifo_depth++;
                        cur_fill++;
                        free_map[pg] = 1'b1;
                    end
                end
            end
            FUNC_INIT:
                rebuild_map();
            default:
                ;
        endcase
        return r;
    endfunction

    // response side: random ready stall after each result, none while no_idle is set
    int rsp_hold;
    always @(posedge clk or negedge rst_n)
    begin
        pfa_rsp_t want;
        int nxt;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rsp_hold = 0;
        end
        else
        begin
            nxt = rsp_hold;
            if (rsp_if.valid && rsp_if.ready)
            begin
                // compare the transfer with the oldest expectation
                if (rsp_expected.size() == 0)
                begin
                    $display("%0t: unexpected rsp transfer %p", $time, rsp_if.payload);
                    errors++;
                end
                else
                begin
                    want = rsp_expected.pop_front();
                    if (rsp_if.payload.alloc_frame !== want.alloc_frame)
                    begin
                        $display("%0t: alloc_frame expected %0d actual %0d", $time,
                                 want.alloc_frame, rsp_if.payload.alloc_frame);
                        errors++;
                    end
                    if (rsp_if.payload.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, rsp_if.payload.status);
                        errors++;
                    end
                    if (rsp_if.payload.source !== want.source)
                    begin
                        $display("%0t: source expected %0d actual %0d", $time,
                                 want.source, rsp_if.payload.source);
                        errors++;
                    end
                end
                nxt = no_idle ? 0 : $urandom_range(0, 3);
            end
            else if (nxt > 0)
                nxt--;
            rsp_hold = nxt;
            rsp_if.ready <= (nxt == 0);
        end
    end

    // one request transfer; expectation from the table or from the model
    task automatic send_req(logic [1:0] f, logic [PAGE_W-1:0] pg,
                            bit typed = 0, pfa_rsp_t typed_rsp = '0);
        int gap;
        pfa_rsp_t r;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= '{func: f, page_frame: pg};
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        r = alloc_predict(f, pg);
        rsp_expected.push_back(typed ? typed_rsp : r);
        n_items++;
        if (f == FUNC_ALLOC)
        begin
            if (r.status == STATUS_OOM)
                n_oom++;
            else
                n_src[r.source]++;
        end
        else if (f == FUNC_FREE)
        begin
            if (r.status == STATUS_FREE0)
                n_free0++;
            else
                n_frees++;
        end
    endtask

    // register write, only once every outstanding rsp has come back
    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (rsp_expected.size() != 0)
            @(posedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= '{index: idx, data: val};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        if (idx == REG_TOTAL_PAGES)
            reg_total = val;
        else
            reg_boot = val;
    endtask

    task automatic set_config(logic [CFG_W-1:0] tot, logic [CFG_W-1:0] boot);
        write_reg(REG_TOTAL_PAGES, tot);
        write_reg(REG_BOOT_PAGES, boot);
        send_req(FUNC_INIT, PAGE_W'($urandom_range(0, 4095)));
    endtask

    // random page, biased toward the low end, the top and the edges
    function automatic logic [PAGE_W-1:0] pick_page();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return '0;
        else if (k == 1)
            return '1;
        else if (k < 6)
            return PAGE_W'($urandom_range(1, 80));
        else
            return PAGE_W'($urandom());
    endfunction

    task automatic random_traffic(int count);
        int k;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                no_idle = ~no_idle;
            k = $urandom_range(0, 99);
            if (k < 46)
                send_req(FUNC_ALLOC, PAGE_W'($urandom()));
            else if (k < 92)
                send_req(FUNC_FREE, pick_page());
            else if (k < 96)
                send_req(FUNC_INIT, PAGE_W'($urandom()));
            else
                send_req(2'd3, PAGE_W'($urandom()));
        end
    endtask

    // directed rows under the reset registers (4096 pages, 256 boot pages)
    typedef struct {
        logic [1:0]        f;
        logic [PAGE_W-1:0] pg;
        bit                typed;
        pfa_rsp_t          want;
    } dir_row_t;

    dir_row_t dir_rows [] = '{
        '{FUNC_ALLOC, 12'd0,    1, '{12'd256,  STATUS_OK,    SRC_BITMAP}},
        '{FUNC_ALLOC, 12'hFFF,  1, '{12'd257,  STATUS_OK,    SRC_BITMAP}},
        '{FUNC_FREE,  12'd0,    1, '{12'd0,    STATUS_FREE0, SRC_NONE}},
        '{FUNC_FREE,  12'hFFF,  1, '{12'd0,    STATUS_OK,    SRC_NONE}},
        '{FUNC_FREE,  12'd1,    1, '{12'd0,    STATUS_OK,    SRC_NONE}},
        '{FUNC_ALLOC, 12'd0,    1, '{12'd1,    STATUS_OK,    SRC_STACK}},
        '{FUNC_ALLOC, 12'd0,    1, '{12'd4095, STATUS_OK,    SRC_STACK}},
        '{FUNC_ALLOC, 12'd0,    1, '{12'd258,  STATUS_OK,    SRC_BITMAP}},
        '{2'd3,       12'hAAA,  1, '{12'd0,    STATUS_OK,    SRC_NONE}},
        '{FUNC_FREE,  12'h555,  0, '{12'd0,    STATUS_OK,    SRC_NONE}},
        '{FUNC_FREE,  12'hAAA,  0, '{12'd0,    STATUS_OK,    SRC_NONE}},
        '{FUNC_INIT,  12'd0,    1, '{12'd0,    STATUS_OK,    SRC_NONE}},
        '{FUNC_ALLOC, 12'd0,    1, '{12'd256,  STATUS_OK,    SRC_BITMAP}},
        '{FUNC_FREE,  12'd256,  0, '{12'd0,    STATUS_OK,    SRC_NONE}},
        '{FUNC_ALLOC, 12'd0,    0, '{12'd0,    STATUS_OK,    SRC_NONE}}
    };

    initial
    begin
        errors  = 0;
        n_items = 0;
        n_oom   = 0;
        n_free0 = 0;
        n_frees = 0;
        n_src   = '{default: 0};
        no_idle = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.payload = '0;
        reg_total = TOTAL_PAGES_RST;
        reg_boot  = BOOT_PAGES_RST;
        rebuild_map();
        for (int i = 0; i < NPAGES; i++)
            lifo[i] = '0;

        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[i])
            send_req(dir_rows[i].f, dir_rows[i].pg, dir_rows[i].typed, dir_rows[i].want);

        // a single page: the bitmap scan finds out of memory and frame zero is refused
        set_config(13'd1, 13'd1);
        send_req(FUNC_ALLOC, '0, 1, '{12'd0, STATUS_OOM, SRC_NONE});
        send_req(FUNC_FREE, '0, 1, '{12'd0, STATUS_FREE0, SRC_NONE});
        // a page above total_pages goes through the stack and back out
        send_req(FUNC_FREE, 12'd5);
        send_req(FUNC_ALLOC, '0);
        send_req(FUNC_ALLOC, '0);
        random_traffic(80);

        // several register settings, the extremes among them
        set_config(13'd33, 13'd1);
        random_traffic(100);
        set_config(13'd4096, 13'd4096);
        random_traffic(60);
        set_config(13'd8191, 13'd0);
        random_traffic(80);
        set_config(13'd70, 13'd40);
        random_traffic(100);
        set_config(13'd4096, 13'd1);
        random_traffic(60);

        // fill a whole frame so the next free becomes a marker, then pop
        // through the marker back into the full frame below it
        set_config(13'd64, 13'd2);
        for (int n = 0; n < FRAME_CAP + 2; n++)
            send_req(FUNC_FREE, PAGE_W'($urandom_range(1, 4095)));
        for (int n = 0; n < 40; n++)
            send_req(FUNC_ALLOC, '0);
        random_traffic(40);

        req_if.valid <= 1'b0;
        while (rsp_expected.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("coverage: %0d requests, %0d frees, %0d frame zero frees, %0d out of memory",
                 n_items, n_frees, n_free0, n_oom);
        $display("allocations: stack %0d, frame marker %0d, bitmap scan %0d",
                 n_src[SRC_STACK], n_src[SRC_RECLAIM], n_src[SRC_BITMAP]);
        if (errors == 0 && rsp_expected.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial
    begin
        #150ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
